@@ sv/link_reconnect_backoff_supervisor_defines.svh @@
// Assertion macros for the link reconnect backoff supervisor.
// Included by the top level only; no other dependencies.
`ifndef LINK_RECONNECT_BACKOFF_SUPERVISOR_DEFINES_SVH
`define LINK_RECONNECT_BACKOFF_SUPERVISOR_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define LRBS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lrbs assertion failed");

// Next-cycle implication, checked outside reset
`define LRBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrbs assertion failed");

`endif

@@ sv/lrbs_pkg.sv @@
// Shared types and constants for the link reconnect backoff supervisor.
// No dependencies.
package lrbs_pkg;

  localparam int unsigned IntervalW = 31;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;

  typedef enum logic [1:0] {
    TICK_RAN           = 2'd0,
    TICK_PAUSED        = 2'd1,
    TICK_NO_BROKER     = 2'd2,
    TICK_FAILOVER_BUSY = 2'd3
  } tick_status_t;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_LINK_INIT    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LINK_MAX     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SESSION_INIT = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SESSION_MAX  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_STAB_WINDOW  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_HARD_RESET   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_FAILOVER     = 3'd6;

  // Register reset values
  localparam logic [IntervalW-1:0] LINK_INIT_RST    = 31'd2000;
  localparam logic [IntervalW-1:0] LINK_MAX_RST     = 31'd300000;
  localparam logic [IntervalW-1:0] SESSION_INIT_RST = 31'd5000;
  localparam logic [IntervalW-1:0] SESSION_MAX_RST  = 31'd300000;
  localparam logic [TimeW-1:0]     STAB_WINDOW_RST  = 32'd60000;
  localparam logic [7:0]           HARD_RESET_RST   = 8'd8;
  localparam logic [7:0]           FAILOVER_RST     = 8'd10;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             status_mode;
    logic             config_reset_active;
    logic             link_up;
    logic             session_up;
    logic             broker_valid;
    logic             failover_busy;
  } tick_t;

  typedef struct packed {
    tick_status_t tick_status;
    logic         link_reconnect;
    logic         session_reconnect;
    logic         session_hard_reset;
    logic         session_failover;
    logic         stability_hint;
    logic [15:0]  link_fail_total;
    logic [7:0]   session_fail_total;
  } result_t;

  // Backoff unit verdict
  typedef struct packed {
    logic                 due;
    logic [IntervalW-1:0] interval_next;
  } backoff_t;

endpackage

@@ sv/lrbs_in_if.sv @@
// Tick input channel: valid/ready handshake with the tick fields.
// No dependencies.
interface lrbs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        status_mode;
  logic        config_reset_active;
  logic        link_up;
  logic        session_up;
  logic        broker_valid;
  logic        failover_busy;

  modport source (
    output valid, now_ms, status_mode, config_reset_active, link_up, session_up,
           broker_valid, failover_busy,
    input  ready
  );
  modport sink (
    input  valid, now_ms, status_mode, config_reset_active, link_up, session_up,
           broker_valid, failover_busy,
    output ready
  );
endinterface

@@ sv/lrbs_out_if.sv @@
// Result output channel: valid/ready handshake with the result fields.
// No dependencies.
interface lrbs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  tick_status;
  logic        link_reconnect;
  logic        session_reconnect;
  logic        session_hard_reset;
  logic        session_failover;
  logic        stability_hint;
  logic [15:0] link_fail_total;
  logic [7:0]  session_fail_total;

  modport source (
    output valid, tick_status, link_reconnect, session_reconnect, session_hard_reset,
           session_failover, stability_hint, link_fail_total, session_fail_total,
    input  ready
  );
  modport sink (
    input  valid, tick_status, link_reconnect, session_reconnect, session_hard_reset,
           session_failover, stability_hint, link_fail_total, session_fail_total,
    output ready
  );
endinterface

@@ sv/lrbs_backoff.sv @@
// Backoff timer check: elapsed time against the interval, and the doubled,
// capped interval for the next try. Depends on lrbs_pkg.
module lrbs_backoff import lrbs_pkg::*; (
  input  logic [TimeW-1:0]     now_ms,
  input  logic [TimeW-1:0]     last_try,
  input  logic [IntervalW-1:0] interval,
  input  logic [IntervalW-1:0] cap,
  output backoff_t             res
);
  logic [TimeW-1:0] elapsed;
  logic [TimeW-1:0] doubled;

  // elapsed wraps modulo 2^32
  assign elapsed = now_ms - last_try;
  assign doubled = {interval, 1'b0};

  always_comb begin
    res.due           = elapsed >= {1'b0, interval};
    res.interval_next = (doubled > {1'b0, cap}) ? cap : doubled[IntervalW-1:0];
  end
endmodule

@@ sv/link_reconnect_backoff_supervisor.sv @@
// Link reconnect backoff supervisor: takes one supervision tick per cycle unless the
// result channel stalls, and returns one result per tick through an input register,
// then a result register. Throughput is one tick per clock while out_ch.ready holds;
// the whole state update is a single pass of subtract-and-compare logic per backoff
// timer. Configuration writes are meant for idle periods; interval registers take
// effect when the corresponding backoff reloads.
`include "link_reconnect_backoff_supervisor_defines.svh"

module link_reconnect_backoff_supervisor import lrbs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  lrbs_in_if.sink             in_ch,
  lrbs_out_if.source          out_ch
);

  // Configuration registers
  logic [IntervalW-1:0] link_init, link_max, session_init, session_max;
  logic [TimeW-1:0]     stab_window;
  logic [7:0]           hard_reset_cnt, failover_cnt;

  // Supervisor state
  logic [15:0]          link_fails, link_fails_next;
  logic [7:0]           session_fails, session_fails_next;
  logic [IntervalW-1:0] link_interval, link_interval_next;
  logic [IntervalW-1:0] session_interval, session_interval_next;
  logic [TimeW-1:0]     last_link_try, last_link_try_next;
  logic [TimeW-1:0]     last_session_try, last_session_try_next;
  logic                 hint_done, hint_done_next;

  // Pipeline
  tick_t   in_q;
  logic    in_q_valid;
  result_t res, res_next;
  logic    out_valid;
  logic    fire;

  backoff_t link_bo, session_bo;
  logic [7:0] session_inc;

  assign fire        = in_q_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !in_q_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_init      <= LINK_INIT_RST;
      link_max       <= LINK_MAX_RST;
      session_init   <= SESSION_INIT_RST;
      session_max    <= SESSION_MAX_RST;
      stab_window    <= STAB_WINDOW_RST;
      hard_reset_cnt <= HARD_RESET_RST;
      failover_cnt   <= FAILOVER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINK_INIT:    link_init      <= cfg_data[IntervalW-1:0];
        REG_LINK_MAX:     link_max       <= cfg_data[IntervalW-1:0];
        REG_SESSION_INIT: session_init   <= cfg_data[IntervalW-1:0];
        REG_SESSION_MAX:  session_max    <= cfg_data[IntervalW-1:0];
        REG_STAB_WINDOW:  stab_window    <= cfg_data[TimeW-1:0];
        REG_HARD_RESET:   hard_reset_cnt <= cfg_data[7:0];
        REG_FAILOVER:     failover_cnt   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_q_valid <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      in_q.now_ms              <= in_ch.now_ms;
      in_q.status_mode         <= in_ch.status_mode;
      in_q.config_reset_active <= in_ch.config_reset_active;
      in_q.link_up             <= in_ch.link_up;
      in_q.session_up          <= in_ch.session_up;
      in_q.broker_valid        <= in_ch.broker_valid;
      in_q.failover_busy       <= in_ch.failover_busy;
    end
  end

  lrbs_backoff u_link_bo (
    .now_ms   (in_q.now_ms),
    .last_try (last_link_try),
    .interval (link_interval),
    .cap      (link_max),
    .res      (link_bo)
  );

  lrbs_backoff u_session_bo (
    .now_ms   (in_q.now_ms),
    .last_try (last_session_try),
    .interval (session_interval),
    .cap      (session_max),
    .res      (session_bo)
  );

  assign session_inc = (session_fails == 8'hFF) ? session_fails : session_fails + 8'd1;

  always_comb begin
    link_fails_next       = link_fails;
    session_fails_next    = session_fails;
    link_interval_next    = link_interval;
    session_interval_next = session_interval;
    last_link_try_next    = last_link_try;
    last_session_try_next = last_session_try;
    hint_done_next        = hint_done;
    res_next              = '0;
    res_next.tick_status  = TICK_RAN;

    if (!in_q.status_mode) begin
      res_next.tick_status = TICK_PAUSED;
    end else begin
      if (!hint_done && (in_q.now_ms > stab_window) && in_q.link_up) begin
        hint_done_next          = 1'b1;
        res_next.stability_hint = 1'b1;
      end

      if (!in_q.config_reset_active && !in_q.link_up) begin
        if (link_fails != 16'hFFFF) begin
          link_fails_next = link_fails + 16'd1;
        end
        if (link_bo.due) begin
          last_link_try_next      = in_q.now_ms;
          res_next.link_reconnect = 1'b1;
          link_interval_next      = link_bo.interval_next;
        end
      end else begin
        link_fails_next    = '0;
        link_interval_next = link_init;
      end

      if (in_q.link_up && !in_q.session_up) begin
        if (!in_q.broker_valid) begin
          res_next.tick_status = TICK_NO_BROKER;
        end else if (in_q.failover_busy) begin
          res_next.tick_status = TICK_FAILOVER_BUSY;
        end else begin
          session_fails_next = session_inc;
          if (session_bo.due) begin
            last_session_try_next      = in_q.now_ms;
            res_next.session_reconnect = 1'b1;
            session_interval_next      = session_bo.interval_next;
          end
          res_next.session_hard_reset = (session_inc == hard_reset_cnt);
          if (session_inc > failover_cnt) begin
            res_next.session_failover = 1'b1;
            session_fails_next        = '0;
          end
        end
      end else begin
        session_fails_next    = '0;
        session_interval_next = session_init;
      end
    end

    res_next.link_fail_total    = link_fails_next;
    res_next.session_fail_total = session_fails_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_fails       <= '0;
      session_fails    <= '0;
      link_interval    <= LINK_INIT_RST;
      session_interval <= SESSION_INIT_RST;
      last_link_try    <= '0;
      last_session_try <= '0;
      hint_done        <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (fire) begin
        link_fails       <= link_fails_next;
        session_fails    <= session_fails_next;
        link_interval    <= link_interval_next;
        session_interval <= session_interval_next;
        last_link_try    <= last_link_try_next;
        last_session_try <= last_session_try_next;
        hint_done        <= hint_done_next;
        out_valid        <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  assign out_ch.valid              = out_valid;
  assign out_ch.tick_status        = res.tick_status;
  assign out_ch.link_reconnect     = res.link_reconnect;
  assign out_ch.session_reconnect  = res.session_reconnect;
  assign out_ch.session_hard_reset = res.session_hard_reset;
  assign out_ch.session_failover   = res.session_failover;
  assign out_ch.stability_hint     = res.stability_hint;
  assign out_ch.link_fail_total    = res.link_fail_total;
  assign out_ch.session_fail_total = res.session_fail_total;

  // A failover clears the session count in the same transaction
  `LRBS_ASSERT_NOW(a_failover_clears, clk, rst, out_valid && res.session_failover,
    res.session_fail_total == 8'd0)
  // Paused ticks raise no request
  `LRBS_ASSERT_NOW(a_paused_quiet, clk, rst, out_valid && res.tick_status == TICK_PAUSED,
    !res.link_reconnect && !res.session_reconnect && !res.stability_hint)
  // Link and session reconnects need opposite link states
  `LRBS_ASSERT_NOW(a_reconnect_excl, clk, rst, out_valid,
    !(res.link_reconnect && res.session_reconnect))
  // The stability hint fires once per reset
  `LRBS_ASSERT_NEXT(a_hint_sticky, clk, rst, hint_done, hint_done)

endmodule

@@ verif/link_reconnect_backoff_supervisor_tb.sv @@
// Self-checking testbench for the link reconnect backoff supervisor.
// Depends on lrbs_pkg, the lrbs_in_if/lrbs_out_if interfaces and the top level.
// Supervision ticks go in through a queue-fed driver; results are checked against a local predictor.
module link_reconnect_backoff_supervisor_tb;
  import lrbs_pkg::*;

  localparam int unsigned CycleLimit  = 2000000;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned SettleTicks = 4;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  lrbs_in_if  in_ch ();
  lrbs_out_if out_ch ();

  link_reconnect_backoff_supervisor DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #4 clk = ~clk;

  // Register copies as the block should hold them
  logic [IntervalW-1:0] cfg_link_init, cfg_link_max, cfg_sess_init, cfg_sess_max;
  logic [TimeW-1:0]     cfg_stab_window;
  logic [7:0]           cfg_hard_reset, cfg_failover;

  // Supervisor state
  logic [15:0] link_fails;
  logic [7:0]  session_fails;
  logic [31:0] link_iv, sess_iv, last_link_try, last_sess_try;
  logic        hint_fired;

  tick_t       pending_ticks[$];
  result_t     tick_results_due[$];
  int unsigned ticks_loaded, ticks_accepted, mismatches;

  logic        tick_taken;
  tick_t       tx_item;
  int unsigned tx_gap, tx_calm, rx_gap, rx_calm, rx_hold;
  int unsigned holds_asked, holds_served;
  logic        fast_mode;
  logic [31:0] clock_ms;

  function automatic logic [31:0] double_capped(logic [31:0] v, logic [31:0] cap);
    logic [32:0] d;
    d = {v, 1'b0};
    return (d > {1'b0, cap}) ? cap : d[31:0];
  endfunction

  function automatic result_t supervise_tick(tick_t t);
    result_t r;
    r = '0;
    r.tick_status = TICK_RAN;
    if (!t.status_mode) begin
      r.tick_status = TICK_PAUSED;
    end else begin
      if (!hint_fired && t.now_ms > cfg_stab_window && t.link_up) begin
        hint_fired = 1'b1;
        r.stability_hint = 1'b1;
      end
      if (!t.config_reset_active && !t.link_up) begin
        if (link_fails != 16'hFFFF) link_fails++;
        if (32'(t.now_ms - last_link_try) >= link_iv) begin
          last_link_try = t.now_ms;
          r.link_reconnect = 1'b1;
          link_iv = double_capped(link_iv, {1'b0, cfg_link_max});
        end
      end else begin
        link_fails = '0;
        link_iv = {1'b0, cfg_link_init};
      end
      if (t.link_up && !t.session_up) begin
        if (!t.broker_valid) begin
          r.tick_status = TICK_NO_BROKER;
        end else if (t.failover_busy) begin
          r.tick_status = TICK_FAILOVER_BUSY;
        end else begin
          if (session_fails != 8'hFF) session_fails++;
          if (32'(t.now_ms - last_sess_try) >= sess_iv) begin
            last_sess_try = t.now_ms;
            r.session_reconnect = 1'b1;
            sess_iv = double_capped(sess_iv, {1'b0, cfg_sess_max});
          end
          if (session_fails == cfg_hard_reset) r.session_hard_reset = 1'b1;
          // failover clears the count after the hard-reset compare
          if (session_fails > cfg_failover) begin
            r.session_failover = 1'b1;
            session_fails = '0;
          end
        end
      end else begin
        session_fails = '0;
        sess_iv = {1'b0, cfg_sess_init};
      end
    end
    r.link_fail_total = link_fails;
    r.session_fail_total = session_fails;
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Accepted transactions on both channels, sampled at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      tick_taken <= 1'b0;
    end else begin
      tick_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        tx_item.now_ms              = in_ch.now_ms;
        tx_item.status_mode         = in_ch.status_mode;
        tx_item.config_reset_active = in_ch.config_reset_active;
        tx_item.link_up             = in_ch.link_up;
        tx_item.session_up          = in_ch.session_up;
        tx_item.broker_valid        = in_ch.broker_valid;
        tx_item.failover_busy       = in_ch.failover_busy;
        tick_results_due.push_back(supervise_tick(tx_item));
        ticks_accepted++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (tick_results_due.size() == 0) begin
          $error("result transaction with no tick outstanding");
          mismatches++;
        end else begin
          result_t want;
          want = tick_results_due.pop_front();
          check_field("tick_status", want.tick_status, out_ch.tick_status);
          check_field("link_reconnect", want.link_reconnect, out_ch.link_reconnect);
          check_field("session_reconnect", want.session_reconnect, out_ch.session_reconnect);
          check_field("session_hard_reset", want.session_hard_reset, out_ch.session_hard_reset);
          check_field("session_failover", want.session_failover, out_ch.session_failover);
          check_field("stability_hint", want.stability_hint, out_ch.stability_hint);
          check_field("link_fail_total", want.link_fail_total, out_ch.link_fail_total);
          check_field("session_fail_total", want.session_fail_total, out_ch.session_fail_total);
        end
      end
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Tick driver
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      tx_gap      <= 0;
      tx_calm     <= 0;
    end else if (!in_ch.valid || tick_taken) begin
      if (tx_calm != 0) tx_calm <= tx_calm - 1;
      else if ($urandom_range(0, 99) == 0) tx_calm <= $urandom_range(20, 100);
      if (tx_gap != 0) begin
        in_ch.valid <= 1'b0;
        tx_gap      <= tx_gap - 1;
      end else if (pending_ticks.size() != 0) begin
        tick_t t;
        t = pending_ticks.pop_front();
        in_ch.now_ms              <= t.now_ms;
        in_ch.status_mode         <= t.status_mode;
        in_ch.config_reset_active <= t.config_reset_active;
        in_ch.link_up             <= t.link_up;
        in_ch.session_up          <= t.session_up;
        in_ch.broker_valid        <= t.broker_valid;
        in_ch.failover_busy       <= t.failover_busy;
        in_ch.valid               <= 1'b1;
        tx_gap <= (fast_mode || tx_calm != 0) ? 0 : gap_len();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver, with an occasional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      rx_gap       <= 0;
      rx_calm      <= 0;
      rx_hold      <= 0;
      holds_served <= 0;
    end else if (rx_hold != 0) begin
      out_ch.ready <= 1'b0;
      rx_hold      <= rx_hold - 1;
    end else if (holds_served != holds_asked) begin
      out_ch.ready <= 1'b0;
      rx_hold      <= LongHold;
      holds_served <= holds_served + 1;
    end else if (rx_gap != 0) begin
      out_ch.ready <= 1'b0;
      rx_gap       <= rx_gap - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (rx_calm != 0) rx_calm <= rx_calm - 1;
      else if ($urandom_range(0, 99) == 0) rx_calm <= $urandom_range(20, 100);
      rx_gap <= (fast_mode || rx_calm != 0) ? 0 : gap_len();
    end
  end

  task automatic load_tick(input logic [31:0] now, input logic sm, input logic cr,
                           input logic lu, input logic su, input logic bv, input logic fb);
    tick_t t;
    t.now_ms              = now;
    t.status_mode         = sm;
    t.config_reset_active = cr;
    t.link_up             = lu;
    t.session_up          = su;
    t.broker_valid        = bv;
    t.failover_busy       = fb;
    pending_ticks.push_back(t);
    ticks_loaded++;
  endtask

  // Waits until every tick is in and every result is out, then lets the pipe settle
  task automatic drain();
    while (ticks_accepted != ticks_loaded || tick_results_due.size() != 0) @(negedge clk);
    repeat (SettleTicks) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [30:0] li, input logic [30:0] lm,
                                input logic [30:0] si, input logic [30:0] sm,
                                input logic [31:0] sw, input logic [7:0] hr,
                                input logic [7:0] fo);
    cfg_link_init   = li;
    cfg_link_max    = lm;
    cfg_sess_init   = si;
    cfg_sess_max    = sm;
    cfg_stab_window = sw;
    cfg_hard_reset  = hr;
    cfg_failover    = fo;
    set_reg(REG_LINK_INIT,    {1'b0, li});
    set_reg(REG_LINK_MAX,     {1'b0, lm});
    set_reg(REG_SESSION_INIT, {1'b0, si});
    set_reg(REG_SESSION_MAX,  {1'b0, sm});
    set_reg(REG_STAB_WINDOW,  sw);
    set_reg(REG_HARD_RESET,   hr);
    set_reg(REG_FAILOVER,     fo);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] time_step();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 3000);
    if (r < 75) return $urandom_range(0, 400000);
    if (r < 92) return $urandom_range(0, 32'h8000_0000);
    return $urandom();
  endfunction

  // Mostly coherent outages with random timing, plus some pure noise
  task automatic load_random_phase(input int unsigned n);
    int unsigned goal, len, kind;
    goal = ticks_loaded + n;
    while (ticks_loaded < goal) begin
      kind = $urandom_range(0, 99);
      len  = $urandom_range(1, 40);
      if (kind < 35) begin
        repeat (len) begin
          clock_ms += time_step();
          load_tick(clock_ms, $urandom_range(0, 19) != 0, $urandom_range(0, 14) == 0,
                    $urandom_range(0, 19) == 0, $urandom_range(0, 1), $urandom_range(0, 1),
                    $urandom_range(0, 1));
        end
      end else if (kind < 70) begin
        repeat (len) begin
          clock_ms += time_step();
          load_tick(clock_ms, $urandom_range(0, 19) != 0, $urandom_range(0, 9) == 0, 1'b1,
                    $urandom_range(0, 29) == 0, $urandom_range(0, 9) != 0,
                    $urandom_range(0, 9) == 0);
        end
      end else if (kind < 85) begin
        repeat (len % 5 + 1) begin
          clock_ms += time_step();
          load_tick(clock_ms, 1'b1, $urandom_range(0, 1), 1'b1, 1'b1, $urandom_range(0, 1),
                    $urandom_range(0, 1));
        end
      end else begin
        load_tick($urandom(), $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                  $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
      end
    end
  endtask

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("FAIL link_reconnect_backoff_supervisor");
    $finish;
  end

  initial begin
    rst                       = 1'b1;
    cfg_we                    = 1'b0;
    cfg_index                 = REG_LINK_INIT;
    cfg_data                  = '0;
    fast_mode                 = 1'b0;
    holds_asked               = 0;
    ticks_loaded              = 0;
    ticks_accepted            = 0;
    mismatches                = 0;
    clock_ms                  = '0;

    cfg_link_init   = LINK_INIT_RST;
    cfg_link_max    = LINK_MAX_RST;
    cfg_sess_init   = SESSION_INIT_RST;
    cfg_sess_max    = SESSION_MAX_RST;
    cfg_stab_window = STAB_WINDOW_RST;
    cfg_hard_reset  = HARD_RESET_RST;
    cfg_failover    = FAILOVER_RST;
    link_fails      = '0;
    session_fails   = '0;
    link_iv         = {1'b0, LINK_INIT_RST};
    sess_iv         = {1'b0, SESSION_INIT_RST};
    last_link_try   = '0;
    last_sess_try   = '0;
    hint_fired      = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed ticks on the reset settings
    load_tick(32'd0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);        // paused, all flags set
    load_tick(32'd100, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);      // link down, too early
    load_tick(32'd2500, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);     // link reconnect due
    load_tick(32'd3000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);     // reset active clears link
    load_tick(32'd4000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);     // no broker
    load_tick(32'd4100, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1);     // failover engine busy
    for (int i = 0; i < 12; i++)                                  // hard reset, then failover
      load_tick(32'd6000 + 32'(i) * 32'd1000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
    load_tick(32'd70000, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);    // stability hint
    load_tick(32'd80000, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);    // hint only once
    load_tick(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
    load_tick(32'h0000_0010, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0); // elapsed across the wrap
    load_tick(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    drain();

    apply_settings(31'd1, 31'd1, 31'd1, 31'd1, 32'd0, 8'd1, 8'd1);
    load_random_phase(200);
    drain();

    apply_settings(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                   32'hFFFF_FFFF, 8'd254, 8'd254);
    load_random_phase(200);
    drain();

    // initial above cap; hard reset one above the failover threshold
    apply_settings(31'd500000, 31'd3000, 31'd400000, 31'd7000, 32'd1000, 8'd6, 8'd5);
    load_random_phase(200);
    holds_asked++;
    drain();

    apply_settings(31'($urandom_range(1, 32'h7FFF_FFFF)), 31'($urandom_range(1, 32'h7FFF_FFFF)),
                   31'($urandom_range(1, 32'h7FFF_FFFF)), 31'($urandom_range(1, 32'h7FFF_FFFF)),
                   $urandom(), 8'($urandom_range(1, 254)), 8'($urandom_range(1, 254)));
    load_random_phase(200);
    drain();

    apply_settings(31'd1, 31'd64, 31'd3, 31'd100, 32'd50000, 8'd2, 8'd3);
    load_random_phase(200);
    drain();

    apply_settings(LINK_INIT_RST, LINK_MAX_RST, SESSION_INIT_RST, SESSION_MAX_RST,
                   STAB_WINDOW_RST, HARD_RESET_RST, FAILOVER_RST);
    load_random_phase(200);
    drain();

    // Session count climbs to its ceiling
    apply_settings(31'd100, 31'd1000, 31'd100, 31'd1000, 32'd0, 8'd254, 8'd254);
    for (int i = 0; i < 260; i++) begin
      clock_ms += 32'd10;
      load_tick(clock_ms, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
    end
    drain();

    // Link-down run back to back, with a long hold-off at the start
    fast_mode = 1'b1;
    for (int i = 0; i < 300; i++) begin
      clock_ms += 32'd1;
      load_tick(clock_ms, 1'b1, 1'b0, 1'b0, $urandom_range(0, 1), $urandom_range(0, 1),
                $urandom_range(0, 1));
    end
    holds_asked++;
    drain();
    fast_mode = 1'b0;

    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS link_reconnect_backoff_supervisor");
    end else begin
      $display("FAIL link_reconnect_backoff_supervisor");
    end
    $finish;
  end

endmodule
